/* rtl/tga_rle_pixel_decoder_top_macros.svh */
// Assertion macros for the TGA run-length pixel decoder.
`ifndef TGA_RLE_PIXEL_DECODER_TOP_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TGA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tga_rle: same-cycle check failed");
`define TGA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tga_rle: next-cycle check failed");
`else
`define TGA_ASSERT_NOW(lbl, ante, cons)
`define TGA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/tga_rle_pkg.sv */
// Shared types and constants of the TGA run-length pixel decoder.
`timescale 1ns / 1ps
`default_nettype none
package tga_rle_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_PIXEL_BYTES  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RLE_MODE     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_TOP   = 3'd4;

	localparam logic [2:0] BPP_RGBA       = 3'd4;
	localparam int         HDR_RUN_BIT    = 7;
	localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;
	localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;

	localparam int DIV_STEPS    = 17;
	localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [2:0]  pixel_bytes;
		logic        rle_mode;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        origin_top;
		logic [31:0] pixel_total;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [16:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [16:0] quot;
		logic [15:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [15:0] dest_col;
		logic [15:0] dest_row;
		logic [7:0]  repeat_count;
		logic        image_done;
	} pix_item_t;

endpackage
`default_nettype wire

/* rtl/tga_rle_if.sv */
// Channel interfaces of the TGA run-length pixel decoder.
`timescale 1ns / 1ps
`default_nettype none
interface tga_rle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       image_start;
	modport source (output valid, output data_byte, output image_start, input ready);
	modport sink (input valid, input data_byte, input image_start, output ready);
endinterface

interface tga_rle_out_if import tga_rle_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [7:0]            red;
	logic [7:0]            green;
	logic [7:0]            blue;
	logic [7:0]            alpha;
	logic [COORD_BITS-1:0] dest_col;
	logic [COORD_BITS-1:0] dest_row;
	logic [7:0]            repeat_count;
	logic                  image_done;
	modport source (output valid, output red, output green, output blue, output alpha,
		output dest_col, output dest_row, output repeat_count, output image_done,
		input ready);
	modport sink (input valid, input red, input green, input blue, input alpha,
		input dest_col, input dest_row, input repeat_count, input image_done,
		output ready);
endinterface

interface tga_rle_cfg_if import tga_rle_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/tga_rle_pixel_decoder_top.sv */
// Top level of the TGA run-length pixel decoder.
//
//  channel   dir  handshake      beat
//  pix_in    in   valid/ready    one byte of pixel data, image_start flag
//  pix_out   out  valid/ready    one colour run with position, count, done flag
//  cfg       in   valid/ready    register index and write data, always ready
//
// One byte is accepted per cycle while input is not held; a result appears in the
// cycle after its byte. A run that moves the next position two or more rows on is
// folded into rows by a bit-serial divider: input holds while it is busy.
// Output stalls back up through a two-entry result queue; input holds when it is full.
// Reset clears all decoder state and loads the register defaults at once.
`timescale 1ns / 1ps
`default_nettype none
`include "tga_rle_pixel_decoder_top_macros.svh"
module tga_rle_pixel_decoder_top import tga_rle_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tga_rle_in_if.sink    pix_in,
	tga_rle_out_if.source pix_out,
	tga_rle_cfg_if.sink   cfg
);
	cfg_t      cfg_st;
	div_req_t  div_req;
	div_rsp_t  div_rsp;
	logic      obuf_full;
	logic      res_vld;
	pix_item_t res_item;
	pix_item_t out_item;

	assign cfg.ready = 1'b1;

	tga_rle_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_vld  (cfg.valid),
		.wr_idx  (cfg.index),
		.wr_data (cfg.data),
		.cfg     (cfg_st)
	);

	tga_rle_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_st),
		.in_vld      (pix_in.valid),
		.in_rdy      (pix_in.ready),
		.data_byte   (pix_in.data_byte),
		.image_start (pix_in.image_start),
		.out_full    (obuf_full),
		.res_vld     (res_vld),
		.res_item    (res_item),
		.div_req     (div_req),
		.div_rsp     (div_rsp)
	);

	tga_rle_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tga_rle_obuf u_obuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_vld  (res_vld),
		.wr_item (res_item),
		.full    (obuf_full),
		.rd_vld  (pix_out.valid),
		.rd_item (out_item),
		.rd_rdy  (pix_out.ready)
	);

	assign pix_out.red          = out_item.red;
	assign pix_out.green        = out_item.green;
	assign pix_out.blue         = out_item.blue;
	assign pix_out.alpha        = out_item.alpha;
	assign pix_out.dest_col     = out_item.dest_col[COORD_BITS-1:0];
	assign pix_out.dest_row     = out_item.dest_row[COORD_BITS-1:0];
	assign pix_out.repeat_count = out_item.repeat_count;
	assign pix_out.image_done   = out_item.image_done;

	`TGA_ASSERT_NOW(a_div_blocks_input, div_rsp.busy, !pix_in.ready)
	`TGA_ASSERT_NOW(a_no_write_when_full, res_vld, !obuf_full)
	`TGA_ASSERT_NEXT(a_div_start_busy, div_req.start, div_rsp.busy)
	`TGA_ASSERT_NEXT(a_div_done_frees, div_rsp.done, !div_rsp.busy)
endmodule
`default_nettype wire

/* rtl/tga_rle_cfg.sv */
// Configuration registers and pixel total of the TGA decoder.
`timescale 1ns / 1ps
`default_nettype none
module tga_rle_cfg import tga_rle_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_vld,
	input  logic [CFG_IDX_BITS-1:0]  wr_idx,
	input  logic [CFG_DATA_BITS-1:0] wr_data,
	output cfg_t                     cfg
);
	cfg_t        cfg_q;
	logic [15:0] mul_a;
	logic [15:0] mul_b;
	logic [31:0] prod;

	always_comb begin
		mul_a = (wr_idx == REG_IMAGE_WIDTH) ? wr_data : cfg_q.image_width;
		mul_b = (wr_idx == REG_IMAGE_HEIGHT) ? wr_data : cfg_q.image_height;
		prod  = mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_bytes  <= BPP_RGBA;
			cfg_q.rle_mode     <= 1'b1;
			cfg_q.image_width  <= 16'd1;
			cfg_q.image_height <= 16'd1;
			cfg_q.origin_top   <= 1'b0;
			cfg_q.pixel_total  <= 32'd1;
		end else if (wr_vld) begin
			unique case (wr_idx)
				REG_PIXEL_BYTES: cfg_q.pixel_bytes <= wr_data[2:0];
				REG_RLE_MODE:    cfg_q.rle_mode <= wr_data[0];
				REG_IMAGE_WIDTH: begin
					cfg_q.image_width <= wr_data;
					cfg_q.pixel_total <= prod;
				end
				REG_IMAGE_HEIGHT: begin
					cfg_q.image_height <= wr_data;
					cfg_q.pixel_total  <= prod;
				end
				REG_ORIGIN_TOP:  cfg_q.origin_top <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule
`default_nettype wire

/* rtl/tga_rle_div.sv */
// Bit-serial divider that folds a long column advance into rows.
`timescale 1ns / 1ps
`default_nettype none
module tga_rle_div import tga_rle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic                    busy_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [15:0]             rem_q;
	logic [16:0]             quo_q;
	logic [15:0]             dvs_q;
	logic [16:0]             trial;
	logic                    ge;
	logic [16:0]             diff;
	logic [15:0]             rem_n;
	logic [16:0]             quo_n;
	logic                    last;

	always_comb begin
		trial = {rem_q, quo_q[16]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
		rem_n = ge ? diff[15:0] : trial[15:0];
		quo_n = {quo_q[15:0], ge};
		last  = cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	always_comb begin
		rsp.busy = busy_q;
		rsp.done = busy_q && last;
		rsp.quot = quo_n;
		rsp.rem  = rem_n;
	end
endmodule
`default_nettype wire

/* rtl/tga_rle_core.sv */
// Packet, pixel and position decode of the TGA byte stream.
`timescale 1ns / 1ps
`default_nettype none
module tga_rle_core import tga_rle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_vld,
	output logic       in_rdy,
	input  logic [7:0] data_byte,
	input  logic       image_start,
	input  logic       out_full,
	output logic       res_vld,
	output pix_item_t  res_item,
	output div_req_t   div_req,
	input  div_rsp_t   div_rsp
);
	logic        await_q, run_q;
	logic [7:0]  left_q;
	logic [1:0]  bip_q;
	logic [23:0] gather_q;
	logic [31:0] written_q;
	logic [15:0] col_q, row_q;

	logic        e_await, e_run;
	logic [7:0]  e_left;
	logic [1:0]  e_bip;
	logic [23:0] e_gather;
	logic [31:0] e_written;
	logic [15:0] e_col, e_row;

	logic        n_await, n_run;
	logic [7:0]  n_left;
	logic [1:0]  n_bip;
	logic [23:0] n_gather;
	logic [31:0] n_written;
	logic [15:0] n_col, n_row;

	logic        acc, live, bpp4, complete, need_div;
	logic [7:0]  alpha, rep_raw, rep;
	logic [31:0] remaining;
	logic [16:0] col_sum, col_wrap;
	logic [15:0] row_out;

	assign in_rdy = !out_full && !div_rsp.busy;
	assign acc    = in_vld && in_rdy;

	always_comb begin
		e_await   = image_start ? 1'b1 : await_q;
		e_run     = image_start ? 1'b0 : run_q;
		e_left    = image_start ? 8'd0 : left_q;
		e_bip     = image_start ? 2'd0 : bip_q;
		e_gather  = image_start ? 24'd0 : gather_q;
		e_written = image_start ? 32'd0 : written_q;
		e_col     = image_start ? 16'd0 : col_q;
		e_row     = image_start ? 16'd0 : row_q;

		n_await   = e_await;
		n_run     = e_run;
		n_left    = e_left;
		n_bip     = e_bip;
		n_gather  = e_gather;
		n_written = e_written;
		n_col     = e_col;
		n_row     = e_row;

		live      = e_written < cfg.pixel_total;
		bpp4      = cfg.pixel_bytes == BPP_RGBA;
		complete  = 1'b0;
		need_div  = 1'b0;
		alpha     = ALPHA_OPAQUE;
		rep_raw   = 8'd1;
		remaining = cfg.pixel_total - e_written;
		rep       = 8'd1;
		col_sum   = '0;
		col_wrap  = '0;
		row_out   = cfg.origin_top ? e_row : (cfg.image_height - 16'd1 - e_row);

		if (live) begin
			if (cfg.rle_mode && e_await) begin
				n_run   = data_byte[HDR_RUN_BIT];
				n_left  = (data_byte & HDR_COUNT_MASK) + 8'd1;
				n_await = 1'b0;
				n_bip   = 2'd0;
			end else begin
				if (e_bip != 2'd3) begin
					unique case (e_bip)
						2'd0:    n_gather[7:0]   = data_byte;
						2'd1:    n_gather[15:8]  = data_byte;
						default: n_gather[23:16] = data_byte;
					endcase
					n_bip    = e_bip + 2'd1;
					complete = !bpp4 && (n_bip == 2'd3);
				end else begin
					complete = 1'b1;
					alpha    = bpp4 ? data_byte : ALPHA_OPAQUE;
				end

				if (complete) begin
					n_bip = 2'd0;
					if (cfg.rle_mode && e_run) begin
						rep_raw = (e_left != 8'd0) ? e_left : 8'd1;
						n_left  = 8'd0;
						n_await = 1'b1;
					end else if (cfg.rle_mode) begin
						if (e_left <= 8'd1) begin
							n_left  = 8'd0;
							n_await = 1'b1;
						end else begin
							n_left = e_left - 8'd1;
						end
					end
					rep       = (remaining < {24'd0, rep_raw}) ? remaining[7:0] : rep_raw;
					n_written = e_written + {24'd0, rep};
					col_sum   = {1'b0, e_col} + {9'd0, rep};
					col_wrap  = col_sum - {1'b0, cfg.image_width};
					if (col_sum < {1'b0, cfg.image_width}) begin
						n_col = col_sum[15:0];
					end else if (col_wrap < {1'b0, cfg.image_width}) begin
						n_col = col_wrap[15:0];
						n_row = e_row + 16'd1;
					end else begin
						need_div = 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		res_vld               = acc && live && complete;
		res_item.red          = n_gather[23:16];
		res_item.green        = n_gather[15:8];
		res_item.blue         = n_gather[7:0];
		res_item.alpha        = alpha;
		res_item.dest_col     = e_col;
		res_item.dest_row     = row_out;
		res_item.repeat_count = rep;
		res_item.image_done   = n_written == cfg.pixel_total;
		div_req.start         = acc && need_div;
		div_req.dividend      = col_sum;
		div_req.divisor       = cfg.image_width;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_q   <= 1'b1;
			run_q     <= 1'b0;
			left_q    <= '0;
			bip_q     <= '0;
			gather_q  <= '0;
			written_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
		end else if (acc) begin
			await_q   <= n_await;
			run_q     <= n_run;
			left_q    <= n_left;
			bip_q     <= n_bip;
			gather_q  <= n_gather;
			written_q <= n_written;
			col_q     <= n_col;
			row_q     <= n_row;
		end else if (div_rsp.done) begin
			col_q <= div_rsp.rem;
			row_q <= row_q + div_rsp.quot[15:0];
		end
	end
endmodule
`default_nettype wire

/* rtl/tga_rle_obuf.sv */
// Two-entry result queue between the decoder and the output channel.
`timescale 1ns / 1ps
`default_nettype none
module tga_rle_obuf import tga_rle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_vld,
	input  pix_item_t wr_item,
	output logic      full,
	output logic      rd_vld,
	output pix_item_t rd_item,
	input  logic      rd_rdy
);
	pix_item_t  ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       rd_fire;

	assign full    = cnt_q == 2'd2;
	assign rd_vld  = cnt_q != 2'd0;
	assign rd_item = ent_q[rd_ptr_q];
	assign rd_fire = rd_vld && rd_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_vld) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_fire) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, wr_vld} - {1'b0, rd_fire};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_vld) begin
			ent_q[wr_ptr_q] <= wr_item;
		end
	end
endmodule
`default_nettype wire

/* dv/testbench.sv */
// Testbench for the TGA run-length pixel decoder: directed and random byte streams checked against a predictor.
`timescale 1ns / 1ps
module testbench;
	import tga_rle_pkg::*;

	localparam int unsigned RANDOM_BYTES  = 1400;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned STALL_LIMIT   = 4000;

	typedef struct {
		logic [7:0] data;
		logic       start;
	} feed_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	tga_rle_in_if  in_ch ();
	tga_rle_out_if out_ch ();
	tga_rle_cfg_if cfg_ch ();

	tga_rle_pixel_decoder_top #(.COORD_BITS(COORD_BITS_DEF)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix_in (in_ch),
		.pix_out(out_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// register mirror
	logic [2:0]  reg_pixel_bytes;
	logic        reg_rle;
	logic [15:0] reg_width;
	logic [15:0] reg_height;
	logic        reg_top;

	// decoder state mirror
	logic        st_await_hdr;
	logic        st_run;
	logic [7:0]  st_left;
	logic [1:0]  st_byte_idx;
	logic [23:0] st_gather;
	logic [31:0] st_written;
	logic [15:0] st_col;
	logic [15:0] st_row;

	feed_beat_t  byte_feed[$];
	pix_item_t   pixel_runs_due[$];
	int unsigned bytes_queued;
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned idle_cycles;
	int unsigned hold_left;
	bit          hold_req;
	bit          byte_taken;
	bit          failed;

	function automatic void clear_decoder();
		st_await_hdr = 1'b1;
		st_run       = 1'b0;
		st_left      = '0;
		st_byte_idx  = '0;
		st_gather    = '0;
		st_written   = '0;
		st_col       = '0;
		st_row       = '0;
	endfunction

	function automatic bit decode_byte(input logic [7:0] b, input logic restart,
		output pix_item_t px);
		logic [31:0] total;
		logic [31:0] remaining;
		logic [31:0] rep;
		logic [31:0] col;
		logic [7:0]  alpha;
		bit          four;
		px = '0;
		if (restart)
			clear_decoder();
		total = 32'(reg_width) * 32'(reg_height);
		if (st_written >= total)
			return 1'b0;
		four = (reg_pixel_bytes == BPP_RGBA);
		if (reg_rle && st_await_hdr) begin
			st_run       = b[HDR_RUN_BIT];
			st_left      = (b & HDR_COUNT_MASK) + 8'd1;
			st_await_hdr = 1'b0;
			st_byte_idx  = '0;
			return 1'b0;
		end
		if (st_byte_idx != 2'd3) begin
			st_gather[8*st_byte_idx +: 8] = b;
			st_byte_idx = st_byte_idx + 2'd1;
			if (four || st_byte_idx != 2'd3)
				return 1'b0;
			alpha = ALPHA_OPAQUE;
		end else begin
			alpha = four ? b : ALPHA_OPAQUE;
		end
		st_byte_idx = '0;
		if (reg_rle && st_run) begin
			rep          = (st_left != 0) ? 32'(st_left) : 32'd1;
			st_left      = '0;
			st_await_hdr = 1'b1;
		end else begin
			rep = 32'd1;
			if (reg_rle) begin
				if (st_left <= 8'd1) begin
					st_left      = '0;
					st_await_hdr = 1'b1;
				end else begin
					st_left = st_left - 8'd1;
				end
			end
		end
		remaining = total - st_written;
		if (rep > remaining)
			rep = remaining;
		px.red          = st_gather[23:16];
		px.green        = st_gather[15:8];
		px.blue         = st_gather[7:0];
		px.alpha        = alpha;
		px.dest_col     = st_col;
		px.dest_row     = reg_top ? st_row : reg_height - 16'd1 - st_row;
		px.repeat_count = rep[7:0];
		st_written = st_written + rep;
		col = 32'(st_col) + rep;
		if (col >= 32'(reg_width)) begin
			st_row = st_row + 16'(col / 32'(reg_width));
			col    = col % 32'(reg_width);
		end
		st_col = col[15:0];
		px.image_done = (st_written == total);
		return 1'b1;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			failed = 1'b1;
		end
	endfunction

	function automatic logic [7:0] pixel_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic void push_byte(input logic [7:0] d, input logic s);
		feed_beat_t fb;
		fb.data  = d;
		fb.start = s;
		byte_feed.push_back(fb);
		bytes_queued++;
	endfunction

	// sample on the rising edge: check results, mirror register writes, predict
	always @(posedge clk) begin
		pix_item_t want;
		pix_item_t got;
		bit        fired;
		fired = 1'b0;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				fired = 1'b1;
				if (pixel_runs_due.size() == 0) begin
					$error("pixel run beat with no expected result");
					failed = 1'b1;
				end else begin
					want = pixel_runs_due.pop_front();
					check_field("red", want.red, out_ch.red);
					check_field("green", want.green, out_ch.green);
					check_field("blue", want.blue, out_ch.blue);
					check_field("alpha", want.alpha, out_ch.alpha);
					check_field("dest_col", want.dest_col, out_ch.dest_col);
					check_field("dest_row", want.dest_row, out_ch.dest_row);
					check_field("repeat_count", want.repeat_count, out_ch.repeat_count);
					check_field("image_done", want.image_done, out_ch.image_done);
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				fired = 1'b1;
				case (cfg_ch.index)
					REG_PIXEL_BYTES:  reg_pixel_bytes = cfg_ch.data[2:0];
					REG_RLE_MODE:     reg_rle         = cfg_ch.data[0];
					REG_IMAGE_WIDTH:  reg_width       = cfg_ch.data[15:0];
					REG_IMAGE_HEIGHT: reg_height      = cfg_ch.data[15:0];
					REG_ORIGIN_TOP:   reg_top         = cfg_ch.data[0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				fired = 1'b1;
				byte_taken = 1'b1;
				if (decode_byte(in_ch.data_byte, in_ch.image_start, got))
					pixel_runs_due.push_back(got);
			end
		end
		idle_cycles = fired ? 0 : idle_cycles + 1;
	end

	// byte driver: hold the beat until taken, then advance or idle
	always @(negedge clk) begin
		if (byte_taken || !in_ch.valid) begin
			if (byte_taken) begin
				void'(byte_feed.pop_front());
				byte_taken = 1'b0;
			end
			if (arst_n && byte_feed.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				in_ch.valid       <= 1'b1;
				in_ch.data_byte   <= byte_feed[0].data;
				in_ch.image_start <= byte_feed[0].start;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_ch.ready <= 1'b0;
		end else if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	task automatic drain();
		do
			@(posedge clk);
		while (byte_feed.size() != 0 || pixel_runs_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input logic [2:0] pb, input logic rle, input logic [15:0] w,
		input logic [15:0] h, input logic top);
		logic [CFG_IDX_BITS-1:0]  idx [5];
		logic [CFG_DATA_BITS-1:0] val [5];
		idx = '{REG_PIXEL_BYTES, REG_RLE_MODE, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT,
			REG_ORIGIN_TOP};
		val = '{16'(pb), 16'(rle), w, h, 16'(top)};
		for (int i = 0; i < 5; i++) begin
			@(negedge clk);
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[i];
			cfg_ch.data  <= val[i];
			do
				@(posedge clk);
			while (!cfg_ch.ready);
		end
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic queue_image();
		logic [2:0]  pb;
		logic        rle;
		logic        top;
		logic        run;
		logic        lead;
		logic [15:0] w;
		logic [15:0] h;
		logic [6:0]  cnt;
		int unsigned eff;
		int unsigned pix_total;
		int unsigned covered;
		int unsigned img_start;
		int unsigned n;
		int unsigned nb;
		pb  = ($urandom_range(9) < 8) ? 3'($urandom_range(3, 4)) : 3'($urandom_range(7));
		rle = 1'($urandom_range(1));
		top = 1'($urandom_range(1));
		w   = 16'($urandom_range(1, 6));
		h   = 16'($urandom_range(1, 6));
		case ($urandom_range(29))
			0: w = 16'hFFFF;
			1: h = 16'hFFFF;
			2: begin
				w = 16'hFFFF;
				h = 16'hFFFF;
			end
			3: w = '0;
			4: h = '0;
			5, 6: w = 16'($urandom_range(7, 300));
			default: ;
		endcase
		drain();
		write_regs(pb, rle, w, h, top);
		eff       = (pb == BPP_RGBA) ? 4 : 3;
		pix_total = 32'(w) * 32'(h);
		covered   = 0;
		img_start = bytes_queued;
		lead      = 1'b1;
		if (pix_total == 0) begin
			for (int k = 0; k < 3; k++)
				push_byte(pixel_byte(), k == 0);
			return;
		end
		if (rle) begin
			while (covered < pix_total && bytes_queued - img_start < 90) begin
				if ($urandom_range(19) == 0) begin
					push_byte(pixel_byte(), lead || $urandom_range(7) == 0);
					lead = 1'b0;
				end
				run = 1'($urandom_range(1));
				case ($urandom_range(9))
					0: cnt = 7'($urandom_range(127));
					1, 2: cnt = 7'($urandom_range(4, 15));
					default: cnt = 7'($urandom_range(3));
				endcase
				push_byte({run, cnt}, lead);
				lead = 1'b0;
				n = run ? 1 : 32'(cnt) + 1;
				if (n > pix_total - covered)
					n = pix_total - covered;
				if (n > 24)
					n = 24;
				nb = n * eff;
				if ($urandom_range(24) == 0)
					nb = $urandom_range(nb);
				repeat (nb) push_byte(pixel_byte(), 1'b0);
				covered += 32'(cnt) + 1;
			end
		end else begin
			n = (pix_total > 30) ? 30 : pix_total;
			for (int k = 0; k < n * eff; k++)
				push_byte(pixel_byte(), k == 0);
		end
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 3)) push_byte(pixel_byte(), 1'b0);
	endtask

	initial begin
		bit hold_done;
		hold_done          = 1'b0;
		arst_n             = 1'b0;
		in_ch.valid        = 1'b0;
		in_ch.data_byte    = '0;
		in_ch.image_start  = 1'b0;
		out_ch.ready       = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = '0;
		cfg_ch.data        = '0;
		reg_pixel_bytes    = BPP_RGBA;
		reg_rle            = 1'b1;
		reg_width          = 16'd1;
		reg_height         = 16'd1;
		reg_top            = 1'b0;
		clear_decoder();
		tx_idle_pct        = 32;
		rx_idle_pct        = 51;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// longest run header, clipped to the image, then a byte past the end
		write_regs(3'd4, 1'b1, 16'd3, 16'd2, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(8'h80, 1'b0); push_byte(8'h01, 1'b0);
		push_byte(8'h12, 1'b0);
		drain();

		// raw then run packet, three-byte pixels, top origin
		write_regs(3'd3, 1'b1, 16'd1, 16'd2, 1'b1);
		push_byte(8'h00, 1'b1);
		push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
		drain();

		// uncompressed with an odd pixel size
		write_regs(3'd7, 1'b0, 16'd1, 16'd1, 1'b0);
		push_byte(8'h5A, 1'b1); push_byte(8'hA5, 1'b0); push_byte(8'h3C, 1'b0);
		drain();

		// largest image: pixel size and mode changed in the middle
		write_regs(3'd4, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
		push_byte(8'h01, 1'b1);
		push_byte(8'hAA, 1'b0); push_byte(8'hBB, 1'b0); push_byte(8'hCC, 1'b0);
		drain();
		write_regs(3'd3, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
		push_byte(8'hDD, 1'b0);
		drain();
		write_regs(3'd4, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
		push_byte(8'h11, 1'b0); push_byte(8'h22, 1'b0);
		push_byte(8'h33, 1'b0); push_byte(8'h44, 1'b0);
		drain();
		write_regs(3'd3, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
		push_byte(8'h55, 1'b0); push_byte(8'h66, 1'b0); push_byte(8'h77, 1'b0);

		bytes_queued = 0;
		while (bytes_queued < RANDOM_BYTES) begin
			if (bytes_queued < RANDOM_BYTES / 3) begin
				tx_idle_pct = 32;
				rx_idle_pct = 51;
			end else if (bytes_queued < 2 * RANDOM_BYTES / 3) begin
				tx_idle_pct = 51;
				rx_idle_pct = 32;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				if (!hold_done) begin
					hold_done = 1'b1;
					drain();
					write_regs(3'd3, 1'b0, 16'd16, 16'd4, 1'b1);
					hold_req = 1'b1;
					for (int k = 0; k < 16 * 4 * 3; k++)
						push_byte(pixel_byte(), k == 0);
				end
			end
			queue_image();
		end
		drain();

		if (!failed && pixel_runs_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/tga_rle_pkg.sv
rtl/tga_rle_if.sv
rtl/tga_rle_cfg.sv
rtl/tga_rle_div.sv
rtl/tga_rle_core.sv
rtl/tga_rle_obuf.sv
rtl/tga_rle_pixel_decoder_top.sv
dv/testbench.sv
